>>> design/lvqp_pkg.sv
`default_nettype none
package lvqp_pkg;

  localparam int unsigned TAG_W        = 8;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned DIV_W        = 16;

  localparam logic [31:0] LCG_MUL = 32'd1194211693;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  // configuration register indexes
  localparam logic [1:0] CFG_BOARD_SIZE   = 2'd0;
  localparam logic [1:0] CFG_RNG_SEED     = 2'd1;
  localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd2;

  localparam logic [4:0]  BOARD_SIZE_RST   = 5'd8;
  localparam logic [31:0] RNG_SEED_RST     = 32'd1;
  localparam logic [15:0] MAX_ATTEMPTS_RST = 16'd1024;

  // control broadcast to every column cell
  typedef struct packed {
    logic clear;
    logic place;
  } lvqp_ctl_t;

endpackage
`default_nettype wire

>>> design/lvqp_cell.sv
`default_nettype none
module lvqp_cell
  import lvqp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lvqp_ctl_t ctl_i,
  input  wire logic      en_i,
  input  wire logic      sel_i,
  input  wire logic      ld_i,
  input  wire logic      rd_i,
  output logic           safe_o,
  output logic           ld_o,
  output logic           rd_o
);

  logic used_q, used_d;
  logic ld_q, ld_d;
  logic rd_q, rd_d;

  // diagonal marks move one column per placed row
  assign ld_o   = ld_q | sel_i;
  assign rd_o   = rd_q | sel_i;
  assign safe_o = en_i & ~(used_q | ld_q | rd_q);

  always_comb begin
    used_d = used_q;
    ld_d   = ld_q;
    rd_d   = rd_q;
    if (ctl_i.clear) begin
      used_d = 1'b0;
      ld_d   = 1'b0;
      rd_d   = 1'b0;
    end else if (ctl_i.place) begin
      used_d = used_q | sel_i;
      ld_d   = ld_i;
      rd_d   = rd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      ld_q   <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      used_q <= used_d;
      ld_q   <= ld_d;
      rd_q   <= rd_d;
    end
  end

endmodule
`default_nettype wire

>>> design/lvqp_mod.sv
`default_nettype none
module lvqp_mod
  import lvqp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DIV_W-1:0]   num_i,
  input  wire logic [POS_W-1:0]   den_i,
  output logic                    done_o,
  output logic [POS_W-1:0]        rem_o
);

  localparam int unsigned SW = $clog2(DIV_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SW-1:0]    step_q, step_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [POS_W-1:0] den_q, den_d;
  logic [POS_W-1:0] rem_q, rem_d;
  logic [POS_W:0]   trial;

  assign done_o = done_q;
  assign rem_o  = rem_q;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[DIV_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = SW'(DIV_W);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = POS_W'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[POS_W-1:0];
      end
      num_d  = {num_q[DIV_W-2:0], 1'b0};
      step_d = step_q - SW'(1);
      if (step_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

endmodule
`default_nettype wire

>>> design/las_vegas_queen_placer_core.sv
`default_nettype none
// Per attempt, each row counts safe columns, steps the generator, divides its upper
// 16 bits by the count and scans to the safe column the remainder picks; a request
// runs until an attempt succeeds or the attempt limit is hit, then emits n results
// (or a failed result), one per cycle with m_axis_tready high. One request at a time.
// Reset: registers return to board 8, seed 1, limit 1024, generator loaded with 1.
module las_vegas_queen_placer_core
  import lvqp_pkg::*;
#(
  parameter int unsigned MAX_QUEENS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] request_tag
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] result_tag, [12:8] row_number,
                                           // [17:13] column_number, [23:18] zero
  output logic             m_axis_tuser,   // [0] solved
  output logic             m_axis_tlast
);

  localparam int unsigned NCOL = (MAX_QUEENS < RESULT_LIMIT) ? MAX_QUEENS : RESULT_LIMIT;
  localparam int unsigned CW   = $clog2(NCOL);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_COUNT, ST_MODGO, ST_DIV, ST_SCAN, ST_EMIT
  } state_e;

  state_e state_q;

  logic [4:0]       board_size_q;
  logic [15:0]      max_attempts_q;
  logic [31:0]      gen_q;
  logic [15:0]      attempt_q;
  logic [TAG_W-1:0] tag_q;
  logic [POS_W-1:0] n_q;
  logic [POS_W-1:0] row_q;
  logic [POS_W-1:0] cnt_q;
  logic [POS_W-1:0] idx_q;
  logic [CW-1:0]    col_q;
  logic [POS_W-1:0] orow_q;
  logic             solved_q;
  logic [POS_W-1:0] qcol_q [NCOL];

  logic [POS_W-1:0] n_eff;
  logic [POS_W-1:0] safe_cnt;
  logic [NCOL-1:0]  safe_vec;
  logic [NCOL-1:0]  ld_vec;
  logic [NCOL-1:0]  rd_vec;
  logic [31:0]      gen_next;
  logic             place;
  lvqp_ctl_t        ctl;
  logic             mod_done;
  logic [POS_W-1:0] mod_rem;
  logic             out_last;
  logic [POS_W-1:0] out_col;
  logic [CW-1:0]    orow_idx;
  logic [CW-1:0]    row_idx;

  always_comb begin
    n_eff = board_size_q;
    if (board_size_q == 5'd0) begin
      n_eff = 5'd1;
    end else if (board_size_q > POS_W'(NCOL)) begin
      n_eff = POS_W'(NCOL);
    end
  end

  assign gen_next = gen_q * LCG_MUL + LCG_ADD;
  assign place    = (state_q == ST_SCAN) && safe_vec[col_q] && (idx_q == '0);
  assign ctl      = {(state_q == ST_START), place};

  for (genvar k = 0; k < NCOL; k++) begin : g_cell
    logic ld_in, rd_in;
    if (k == 0) begin : g_first
      assign ld_in = 1'b0;
    end else begin : g_mid_l
      assign ld_in = ld_vec[k-1];
    end
    if (k == NCOL - 1) begin : g_last
      assign rd_in = 1'b0;
    end else begin : g_mid_r
      assign rd_in = rd_vec[k+1];
    end
    lvqp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .en_i   (POS_W'(k) < n_q),
      .sel_i  (place && (col_q == CW'(k))),
      .ld_i   (ld_in),
      .rd_i   (rd_in),
      .safe_o (safe_vec[k]),
      .ld_o   (ld_vec[k]),
      .rd_o   (rd_vec[k])
    );
  end

  always_comb begin
    safe_cnt = '0;
    for (int k = 0; k < NCOL; k++) begin
      safe_cnt = safe_cnt + POS_W'(safe_vec[k]);
    end
  end

  lvqp_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_MODGO),
    .num_i   (gen_q[31:16]),
    .den_i   (cnt_q),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign row_idx  = CW'(row_q - POS_W'(1));
  assign orow_idx = CW'(orow_q - POS_W'(1));
  assign out_col  = solved_q ? qcol_q[orow_idx] : '0;
  assign out_last = !solved_q || (orow_q == n_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata  = {6'd0, out_col, (solved_q ? orow_q : POS_W'(0)), tag_q};
  assign m_axis_tuser  = solved_q;
  assign m_axis_tlast  = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      board_size_q   <= BOARD_SIZE_RST;
      max_attempts_q <= MAX_ATTEMPTS_RST;
      gen_q          <= RNG_SEED_RST;
      attempt_q      <= '0;
      n_q            <= '0;
      row_q          <= '0;
      cnt_q          <= '0;
      idx_q          <= '0;
      col_q          <= '0;
      orow_q         <= '0;
      solved_q       <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            n_q       <= n_eff;
            attempt_q <= '0;
            if (max_attempts_q == '0) begin
              solved_q <= 1'b0;
              state_q  <= ST_EMIT;
            end else begin
              state_q <= ST_START;
            end
          end
        end
        ST_START: begin
          attempt_q <= attempt_q + 16'd1;
          row_q     <= POS_W'(1);
          state_q   <= ST_COUNT;
        end
        ST_COUNT: begin
          cnt_q <= safe_cnt;
          if (safe_cnt == '0) begin
            // dead end: retry or give up
            if (attempt_q < max_attempts_q) begin
              state_q <= ST_START;
            end else begin
              solved_q <= 1'b0;
              state_q  <= ST_EMIT;
            end
          end else begin
            gen_q   <= gen_next;
            state_q <= ST_MODGO;
          end
        end
        ST_MODGO: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (mod_done) begin
            idx_q   <= mod_rem;
            col_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (place) begin
            if (row_q == n_q) begin
              solved_q <= 1'b1;
              orow_q   <= POS_W'(1);
              state_q  <= ST_EMIT;
            end else begin
              row_q   <= row_q + POS_W'(1);
              state_q <= ST_COUNT;
            end
          end else begin
            if (safe_vec[col_q]) begin
              idx_q <= idx_q - POS_W'(1);
            end
            col_q <= col_q + CW'(1);
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            if (out_last) begin
              state_q <= ST_IDLE;
            end else begin
              orow_q <= orow_q + POS_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BOARD_SIZE:   board_size_q   <= cfg_data_i[4:0];
          CFG_RNG_SEED:     gen_q          <= cfg_data_i;
          CFG_MAX_ATTEMPTS: max_attempts_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // hold tag and placed columns
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tag_q <= s_axis_tdata;
    end
    if (place) begin
      qcol_q[row_idx] <= POS_W'(col_q) + POS_W'(1);
    end
  end

endmodule
`default_nettype wire
